/* sv/rmq_pkg.sv */
package rmq_pkg;

    localparam int ENT_W    = 17;
    localparam int VEC_W    = 33;
    localparam int MAG_W    = 31;
    localparam int SQ_W     = 62;
    localparam int SUM_W    = 64;
    localparam int ROOT_W   = 32;
    localparam int SH_W     = 5;
    localparam int NORM_MSB = 30;
    localparam int LANES    = 4;

    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r01;
        logic signed [15:0] r02;
        logic signed [15:0] r10;
        logic signed [15:0] r11;
        logic signed [15:0] r12;
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
    } matrix_t;

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic               status;
    } quat_t;

    typedef struct packed {
        logic                         deg;
        logic [LANES-1:0]             neg;
        logic [LANES-1:0][MAG_W-1:0]  mag;
    } root_side_t;

    typedef struct packed {
        logic             deg;
        logic [LANES-1:0] neg;
    } div_side_t;

endpackage

/* sv/rmq_isqrt.sv */
module rmq_isqrt
    import rmq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [SUM_W-1:0]  radicand,
    input  root_side_t        in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] root,
    output root_side_t        out_side
);

    localparam int STEPS = ROOT_W;

    logic             valid_reg [STEPS];
    logic [SUM_W-1:0] x_reg     [STEPS];
    logic [SUM_W-1:0] r_reg     [STEPS];
    root_side_t       side_reg  [STEPS];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);

        logic             v_in;
        logic [SUM_W-1:0] x_in;
        logic [SUM_W-1:0] r_in;
        root_side_t       s_in;
        logic [SUM_W-1:0] trial;
        logic [SUM_W-1:0] x_next;
        logic [SUM_W-1:0] r_next;

        if (k == 0)
        begin : g_first
            assign v_in = in_valid;
            assign x_in = radicand;
            assign r_in = '0;
            assign s_in = in_side;
        end
        else
        begin : g_rest
            assign v_in = valid_reg[k-1];
            assign x_in = x_reg[k-1];
            assign r_in = r_reg[k-1];
            assign s_in = side_reg[k-1];
        end

        assign trial = r_in + BIT;

        always_comb
        begin
            if (x_in >= trial)
            begin
                x_next = x_in - trial;
                r_next = (r_in >> 1) + BIT;
            end
            else
            begin
                x_next = x_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else
                valid_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            x_reg[k]    <= x_next;
            r_reg[k]    <= r_next;
            side_reg[k] <= s_in;
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign root      = r_reg[STEPS-1][ROOT_W-1:0];
    assign out_side  = side_reg[STEPS-1];

endmodule

/* sv/rmq_div.sv */
module rmq_div
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 14
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [MAG_W+FRAC_BITS:0]        num     [LANES],
    input  logic [ROOT_W-1:0]               divisor,
    input  div_side_t                       in_side,
    output logic                            out_valid,
    output logic [FRAC_BITS:0]              quo     [LANES],
    output div_side_t                       out_side
);

    localparam int NUM_W = MAG_W + FRAC_BITS + 1;
    localparam int Q_B   = FRAC_BITS + 1;
    localparam int STEPS = Q_B;

    logic              valid_reg [STEPS];
    logic [ROOT_W-1:0] rem_reg   [STEPS][LANES];
    logic [Q_B-1:0]    q_reg     [STEPS][LANES];
    logic [Q_B-1:0]    low_reg   [STEPS][LANES];
    logic [ROOT_W-1:0] div_reg   [STEPS];
    div_side_t         side_reg  [STEPS];

    for (genvar j = 0; j < STEPS; j++)
    begin : g_step
        logic              v_in;
        logic [ROOT_W-1:0] d_in;
        div_side_t         s_in;
        logic [ROOT_W-1:0] rem_in  [LANES];
        logic [Q_B-1:0]    q_in    [LANES];
        logic [Q_B-1:0]    low_in  [LANES];
        logic [ROOT_W-1:0] rem_next[LANES];
        logic [Q_B-1:0]    q_next  [LANES];

        if (j == 0)
        begin : g_first
            assign v_in = in_valid;
            assign d_in = divisor;
            assign s_in = in_side;
            for (genvar l = 0; l < LANES; l++)
            begin : g_lane
                assign rem_in[l] = ROOT_W'(num[l][NUM_W-1:Q_B]);
                assign q_in[l]   = '0;
                assign low_in[l] = num[l][Q_B-1:0];
            end
        end
        else
        begin : g_rest
            assign v_in = valid_reg[j-1];
            assign d_in = div_reg[j-1];
            assign s_in = side_reg[j-1];
            for (genvar l = 0; l < LANES; l++)
            begin : g_lane
                assign rem_in[l] = rem_reg[j-1][l];
                assign q_in[l]   = q_reg[j-1][l];
                assign low_in[l] = low_reg[j-1][l];
            end
        end

        always_comb
        begin
            logic [ROOT_W:0] trial;
            for (int l = 0; l < LANES; l++)
            begin
                trial = {rem_in[l], low_in[l][Q_B-1-j]};
                if (trial >= {1'b0, d_in})
                begin
                    rem_next[l] = ROOT_W'(trial - {1'b0, d_in});
                    q_next[l]   = {q_in[l][Q_B-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = trial[ROOT_W-1:0];
                    q_next[l]   = {q_in[l][Q_B-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j] <= 1'b0;
            else
                valid_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            div_reg[j]  <= d_in;
            side_reg[j] <= s_in;
            for (int l = 0; l < LANES; l++)
            begin
                rem_reg[j][l] <= rem_next[l];
                q_reg[j][l]   <= q_next[l];
                low_reg[j][l] <= low_in[l];
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

    for (genvar l = 0; l < LANES; l++)
    begin : g_out
        assign quo[l] = q_reg[STEPS-1][l];
    end

endmodule

/* sv/rotation_matrix_to_quaternion_top.sv */
// Rotation matrix to unit quaternion (Shepperd's method). Each transaction on
// start/matrix yields one result on quat, marked by a one-cycle done strobe;
// busy never rises, so a new matrix may enter every cycle and the receiver
// cannot stall the pipeline. The pipeline is made of a 32-stage square-root
// pipeline and a (FRAC_BITS + 1)-stage restoring divider, one quotient bit per
// stage, plus eight single stages: six for clamp, pivot selection, magnitude,
// normalization, squaring and summing ahead of the square root, one for the
// rounding offset and one for the output clamp. status = 1 marks a degenerate
// matrix with an all-zero quaternion.
module rotation_matrix_to_quaternion_top
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 14
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  matrix_t matrix,
    output logic    busy,
    output logic    done,
    output quat_t   quat
);

    localparam int NUM_W = MAG_W + FRAC_BITS + 1;
    localparam int Q_B   = FRAC_BITS + 1;
    localparam int LAT   = 8 + ROOT_W + FRAC_BITS + 1;
    localparam logic signed [VEC_W-1:0] ONE     = VEC_W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [VEC_W-1:0] POS_MAX = VEC_W'(32767);
    localparam logic signed [VEC_W-1:0] NEG_MIN = -VEC_W'(32768);

    logic                    v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic                    num_v_reg, out_v_reg;
    logic signed [15:0]      raw     [9];
    logic signed [ENT_W-1:0] m_next  [9];
    logic signed [ENT_W-1:0] m_reg   [9];
    logic signed [VEC_W-1:0] v_next  [LANES];
    logic signed [VEC_W-1:0] v_reg   [LANES];
    logic                    deg_next;
    logic                    deg2_reg, deg3_reg, deg4_reg, deg5_reg, deg6_reg;
    logic [MAG_W-1:0]        mag3_next [LANES];
    logic [MAG_W-1:0]        mag3_reg  [LANES];
    logic [LANES-1:0]        neg3_next;
    logic [LANES-1:0]        neg3_reg, neg4_reg, neg5_reg, neg6_reg;
    logic [MAG_W-1:0]        top_or;
    logic [SH_W-1:0]         shift;
    logic [MAG_W-1:0]        mag4_reg  [LANES];
    logic [MAG_W-1:0]        mag5_reg  [LANES];
    logic [MAG_W-1:0]        mag6_reg  [LANES];
    logic [SQ_W-1:0]         sq_reg    [LANES];
    logic [SUM_W-1:0]        sum_reg;
    root_side_t              sq_side;
    logic                    root_v;
    logic [ROOT_W-1:0]       root;
    root_side_t              root_side;
    logic [NUM_W-1:0]        num_reg   [LANES];
    logic [ROOT_W-1:0]       n_reg;
    div_side_t               num_side_reg;
    logic                    div_v;
    logic [Q_B-1:0]          quo       [LANES];
    div_side_t               div_side;
    logic signed [15:0]      q_next    [LANES];
    quat_t                   quat_reg;

    assign busy = 1'b0;

    assign raw[0] = matrix.r00;
    assign raw[1] = matrix.r01;
    assign raw[2] = matrix.r02;
    assign raw[3] = matrix.r10;
    assign raw[4] = matrix.r11;
    assign raw[5] = matrix.r12;
    assign raw[6] = matrix.r20;
    assign raw[7] = matrix.r21;
    assign raw[8] = matrix.r22;

    always_comb
    begin
        logic signed [VEC_W-1:0] e;
        for (int i = 0; i < 9; i++)
        begin
            e = VEC_W'(raw[i]);
            if (e > ONE)
                e = ONE;
            if (e < -ONE)
                e = -ONE;
            m_next[i] = e[ENT_W-1:0];
        end
    end

    always_comb
    begin
        logic signed [VEC_W-1:0] a00, a11, a22, t, s1, s2, s3;
        logic signed [VEC_W-1:0] s01, s02, s12, d21, d02, d10;
        a00 = VEC_W'(m_reg[0]);
        a11 = VEC_W'(m_reg[4]);
        a22 = VEC_W'(m_reg[8]);
        t   = ONE + a00 + a11 + a22;
        s1  = ONE + a00 - a11 - a22;
        s2  = ONE - a00 + a11 - a22;
        s3  = ONE - a00 - a11 + a22;
        s01 = VEC_W'(m_reg[1]) + VEC_W'(m_reg[3]);
        s02 = VEC_W'(m_reg[2]) + VEC_W'(m_reg[6]);
        s12 = VEC_W'(m_reg[5]) + VEC_W'(m_reg[7]);
        d21 = VEC_W'(m_reg[7]) - VEC_W'(m_reg[5]);
        d02 = VEC_W'(m_reg[2]) - VEC_W'(m_reg[6]);
        d10 = VEC_W'(m_reg[3]) - VEC_W'(m_reg[1]);
        deg_next = 1'b0;
        if (t > 0)
        begin
            v_next[0] = d21; v_next[1] = d02; v_next[2] = d10; v_next[3] = t;
        end
        else if (s1 >= s2 && s1 >= s3 && s1 > 0)
        begin
            v_next[0] = s1; v_next[1] = s01; v_next[2] = s02; v_next[3] = d21;
        end
        else if (s2 >= s3 && s2 > 0)
        begin
            v_next[0] = s01; v_next[1] = s2; v_next[2] = s12; v_next[3] = d02;
        end
        else if (s3 > s2 && s3 > 0)
        begin
            v_next[0] = s02; v_next[1] = s12; v_next[2] = s3; v_next[3] = d10;
        end
        else
        begin
            v_next[0] = '0; v_next[1] = '0; v_next[2] = '0; v_next[3] = '0;
            deg_next  = 1'b1;
        end
    end

    always_comb
    begin
        logic signed [VEC_W-1:0] a;
        for (int l = 0; l < LANES; l++)
        begin
            neg3_next[l] = v_reg[l][VEC_W-1];
            a            = neg3_next[l] ? -v_reg[l] : v_reg[l];
            mag3_next[l] = a[MAG_W-1:0];
        end
    end

    always_comb
    begin
        top_or = '0;
        for (int l = 0; l < LANES; l++)
            top_or = top_or | mag3_reg[l];
        shift = '0;
        for (int i = 0; i < MAG_W; i++)
            if (top_or[i])
                shift = SH_W'(NORM_MSB - i);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            v6_reg    <= 1'b0;
            num_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            v1_reg    <= start && !busy;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            v6_reg    <= v5_reg;
            num_v_reg <= root_v;
            out_v_reg <= div_v;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        v_reg    <= v_next;
        deg2_reg <= deg_next;
        mag3_reg <= mag3_next;
        neg3_reg <= neg3_next;
        deg3_reg <= deg2_reg;
        for (int l = 0; l < LANES; l++)
        begin
            mag4_reg[l] <= mag3_reg[l] << shift;
            sq_reg[l]   <= SQ_W'(mag4_reg[l]) * SQ_W'(mag4_reg[l]);
        end
        neg4_reg <= neg3_reg;
        deg4_reg <= deg3_reg;
        mag5_reg <= mag4_reg;
        neg5_reg <= neg4_reg;
        deg5_reg <= deg4_reg;
        sum_reg  <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1])
                  + SUM_W'(sq_reg[2]) + SUM_W'(sq_reg[3]);
        mag6_reg <= mag5_reg;
        neg6_reg <= neg5_reg;
        deg6_reg <= deg5_reg;
    end

    always_comb
    begin
        sq_side.deg = deg6_reg;
        sq_side.neg = neg6_reg;
        for (int l = 0; l < LANES; l++)
            sq_side.mag[l] = mag6_reg[l];
    end

    rmq_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v6_reg),
        .radicand  (sum_reg),
        .in_side   (sq_side),
        .out_valid (root_v),
        .root      (root),
        .out_side  (root_side)
    );

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
            num_reg[l] <= (NUM_W'(root_side.mag[l]) << FRAC_BITS) + NUM_W'(root >> 1);
        n_reg            <= root;
        num_side_reg.deg <= root_side.deg;
        num_side_reg.neg <= root_side.neg;
    end

    rmq_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (num_v_reg),
        .num       (num_reg),
        .divisor   (n_reg),
        .in_side   (num_side_reg),
        .out_valid (div_v),
        .quo       (quo),
        .out_side  (div_side)
    );

    always_comb
    begin
        logic signed [VEC_W-1:0] qv;
        for (int l = 0; l < LANES; l++)
        begin
            qv = VEC_W'(quo[l]);
            if (qv > ONE)
                qv = ONE;
            if (div_side.neg[l])
                qv = -qv;
            if (qv > POS_MAX)
                qv = POS_MAX;
            if (qv < NEG_MIN)
                qv = NEG_MIN;
            q_next[l] = div_side.deg ? 16'sd0 : qv[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        quat_reg.quat_x <= q_next[0];
        quat_reg.quat_y <= q_next[1];
        quat_reg.quat_z <= q_next[2];
        quat_reg.quat_w <= q_next[3];
        quat_reg.status <= div_side.deg;
    end

    assign done = out_v_reg;
    assign quat = quat_reg;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("transaction did not complete at the fixed latency");

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && quat.status) |-> (quat.quat_x == 0 && quat.quat_y == 0
                                   && quat.quat_z == 0 && quat.quat_w == 0))
        else $error("degenerate result carries a nonzero quaternion");

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(div_v))
        else $error("done without a divider result");
`endif

endmodule

/* tb/rotation_matrix_to_quaternion_checker.sv */
module rotation_matrix_to_quaternion_checker
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 14
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  matrix_t matrix,
    input  logic    done,
    input  quat_t   quat,
    output int      errors,
    output int      pending
);

    localparam longint ONE_FX = longint'(1) << FRAC_BITS;

    quat_t quat_expected[$];

    function automatic longint clamp_entry(logic signed [15:0] raw);
        longint v;
        v = longint'(raw);
        if (v > ONE_FX) v = ONE_FX;
        if (v < -ONE_FX) v = -ONE_FX;
        return v;
    endfunction

    function automatic longint unsigned int_root(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic quat_t predict_quat(matrix_t mx);
        longint m[9];
        longint v[4];
        longint unsigned mag[4];
        bit neg[4];
        longint unsigned top;
        longint unsigned sum;
        longint unsigned n;
        longint unsigned qm;
        longint t, s1, s2, s3, q;
        logic signed [15:0] res[4];
        quat_t r;
        m[0] = clamp_entry(mx.r00); m[1] = clamp_entry(mx.r01); m[2] = clamp_entry(mx.r02);
        m[3] = clamp_entry(mx.r10); m[4] = clamp_entry(mx.r11); m[5] = clamp_entry(mx.r12);
        m[6] = clamp_entry(mx.r20); m[7] = clamp_entry(mx.r21); m[8] = clamp_entry(mx.r22);
        t  = ONE_FX + m[0] + m[4] + m[8];
        s1 = ONE_FX + m[0] - m[4] - m[8];
        s2 = ONE_FX - m[0] + m[4] - m[8];
        s3 = ONE_FX - m[0] - m[4] + m[8];
        r = '0;
        if (t > 0)
        begin
            v[0] = m[7] - m[5]; v[1] = m[2] - m[6]; v[2] = m[3] - m[1]; v[3] = t;
        end
        else if (s1 >= s2 && s1 >= s3 && s1 > 0)
        begin
            v[0] = s1; v[1] = m[1] + m[3]; v[2] = m[2] + m[6]; v[3] = m[7] - m[5];
        end
        else if (s2 >= s3 && s2 > 0)
        begin
            v[0] = m[1] + m[3]; v[1] = s2; v[2] = m[5] + m[7]; v[3] = m[2] - m[6];
        end
        else if (s3 > s2 && s3 > 0)
        begin
            v[0] = m[2] + m[6]; v[1] = m[5] + m[7]; v[2] = s3; v[3] = m[3] - m[1];
        end
        else
        begin
            r.status = 1'b1;
            return r;
        end
        top = 0;
        for (int i = 0; i < 4; i++)
        begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
            if (mag[i] > top) top = mag[i];
        end
        while (top < (64'd1 << 30))
        begin
            top = top << 1;
            for (int i = 0; i < 4; i++) mag[i] = mag[i] << 1;
        end
        sum = 0;
        for (int i = 0; i < 4; i++) sum = sum + mag[i] * mag[i];
        n = int_root(sum);
        if (n == 0) n = 1;
        for (int i = 0; i < 4; i++)
        begin
            qm = (mag[i] * longint'(ONE_FX) + (n >> 1)) / n;
            if (qm > ONE_FX) qm = ONE_FX;
            q = neg[i] ? -longint'(qm) : longint'(qm);
            if (q > ONE_FX) q = ONE_FX;
            if (q < -ONE_FX) q = -ONE_FX;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            res[i] = q[15:0];
        end
        r.quat_x = res[0]; r.quat_y = res[1]; r.quat_z = res[2]; r.quat_w = res[3];
        r.status = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    initial errors = 0;
    assign pending = quat_expected.size();

    always @(posedge clk)
    begin
        quat_t want;
        if (rst_n)
        begin
            if (start && !busy)
                quat_expected.push_back(predict_quat(matrix));
            if (done)
            begin
                if (quat_expected.size() == 0)
                begin
                    report_mismatch("unexpected result", 1, 0);
                end
                else
                begin
                    want = quat_expected.pop_front();
                    if (quat.quat_x !== want.quat_x)
                        report_mismatch("quat_x", quat.quat_x, want.quat_x);
                    if (quat.quat_y !== want.quat_y)
                        report_mismatch("quat_y", quat.quat_y, want.quat_y);
                    if (quat.quat_z !== want.quat_z)
                        report_mismatch("quat_z", quat.quat_z, want.quat_z);
                    if (quat.quat_w !== want.quat_w)
                        report_mismatch("quat_w", quat.quat_w, want.quat_w);
                    if (quat.status !== want.status)
                        report_mismatch("status", quat.status, want.status);
                end
            end
        end
    end

endmodule

/* tb/rotation_matrix_to_quaternion_top_test.sv */
module rotation_matrix_to_quaternion_top_test;
    import rmq_pkg::*;

    localparam int FRAC_BITS = 14;
    localparam int ONE = 1 << FRAC_BITS;
    localparam int LATENCY = 41 + FRAC_BITS;
    localparam int CYCLE_LIMIT = 200000;

    logic    clk;
    logic    rst_n;
    logic    start;
    matrix_t matrix;
    logic    busy;
    logic    done;
    quat_t   quat;
    int      errors;
    int      pending;
    int      cycles;
    int      idle_pct;

    rotation_matrix_to_quaternion_top #(.FRAC_BITS(FRAC_BITS)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .matrix(matrix),
        .busy(busy), .done(done), .quat(quat)
    );

    rotation_matrix_to_quaternion_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .matrix(matrix),
        .done(done), .quat(quat), .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic logic signed [15:0] rand_entry();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 16'($urandom);
        if (k == 1) return 16'(ONE);
        if (k == 2) return 16'(-ONE);
        if (k == 3) return 16'sd0;
        return 16'($urandom_range(0, 2 * ONE) - ONE);
    endfunction

    function automatic matrix_t rotation_like();
        matrix_t mx;
        int p;
        int s[3];
        logic signed [15:0] d[3];
        p = $urandom_range(0, 5);
        for (int i = 0; i < 3; i++)
        begin
            s[i] = $urandom_range(0, 1) ? 1 : -1;
            d[i] = 16'(s[i] * int'($urandom_range(ONE - 600, ONE)));
        end
        mx = '0;
        mx.r00 = 16'($urandom_range(0, 400) - 200);
        mx.r11 = 16'($urandom_range(0, 400) - 200);
        mx.r22 = 16'($urandom_range(0, 400) - 200);
        mx.r01 = 16'($urandom_range(0, 400) - 200);
        mx.r02 = 16'($urandom_range(0, 400) - 200);
        mx.r10 = 16'($urandom_range(0, 400) - 200);
        mx.r12 = 16'($urandom_range(0, 400) - 200);
        mx.r20 = 16'($urandom_range(0, 400) - 200);
        mx.r21 = 16'($urandom_range(0, 400) - 200);
        case (p)
            0: begin mx.r00 = d[0]; mx.r11 = d[1]; mx.r22 = d[2]; end
            1: begin mx.r00 = d[0]; mx.r12 = d[1]; mx.r21 = d[2]; end
            2: begin mx.r01 = d[0]; mx.r10 = d[1]; mx.r22 = d[2]; end
            3: begin mx.r01 = d[0]; mx.r12 = d[1]; mx.r20 = d[2]; end
            4: begin mx.r02 = d[0]; mx.r10 = d[1]; mx.r21 = d[2]; end
            default: begin mx.r02 = d[0]; mx.r11 = d[1]; mx.r20 = d[2]; end
        endcase
        return mx;
    endfunction

    function automatic matrix_t noise_matrix();
        matrix_t mx;
        mx.r00 = rand_entry(); mx.r01 = rand_entry(); mx.r02 = rand_entry();
        mx.r10 = rand_entry(); mx.r11 = rand_entry(); mx.r12 = rand_entry();
        mx.r20 = rand_entry(); mx.r21 = rand_entry(); mx.r22 = rand_entry();
        return mx;
    endfunction

    function automatic matrix_t diag(int a, int b, int c);
        matrix_t mx;
        mx = '0;
        mx.r00 = 16'(a); mx.r11 = 16'(b); mx.r22 = 16'(c);
        return mx;
    endfunction

    task automatic send_matrix(matrix_t mx);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        matrix <= mx;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial
    begin
        matrix_t mx;
        rst_n    = 1'b0;
        start    = 1'b0;
        matrix   = '0;
        idle_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_matrix(diag(ONE, ONE, ONE));
        send_matrix(diag(ONE, -ONE, -ONE));
        send_matrix(diag(-ONE, ONE, -ONE));
        send_matrix(diag(-ONE, -ONE, ONE));
        send_matrix(diag(-ONE, -ONE, -ONE));
        send_matrix(diag(0, 0, 0));
        send_matrix(diag(-ONE / 2, -ONE / 2, 0));
        send_matrix(diag(-ONE / 3, -ONE / 3, -ONE / 3));
        send_matrix(diag(0, 0, -ONE));
        send_matrix(diag(-ONE, 0, 0));
        send_matrix(diag(32767, 32767, 32767));
        send_matrix(diag(-32768, -32768, -32768));
        mx = '1;
        send_matrix(mx);
        mx = {9{16'sh7fff}};
        send_matrix(mx);
        mx = {9{16'sh8000}};
        send_matrix(mx);
        mx = {9{16'sh5555}};
        send_matrix(mx);
        mx = {9{16'shaaaa}};
        send_matrix(mx);
        mx = diag(0, -ONE, 0);
        mx.r02 = ONE; mx.r20 = -ONE;
        send_matrix(mx);
        mx = diag(0, 0, ONE);
        mx.r01 = -ONE; mx.r10 = ONE;
        send_matrix(mx);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 17 : ((phase == 1) ? 57 : 0);
            for (int i = 0; i < 350; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_matrix(noise_matrix());
                else
                    send_matrix(rotation_like());
                if (i == 175)
                    drain();
            end
            drain();
        end

        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
